@@ rtl/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// Shared widths, defaults and codes for the paged bump allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   // Fixed field widths
   localparam int unsigned SIZE_W       = 16;
   localparam int unsigned NEED_W       = 17;   // aligned size, up to 65535 + alignment - 1
   localparam int unsigned PAGE_IDX_W   = 4;
   localparam int unsigned OFFSET_W     = 16;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned REQ_DATA_W   = 16;
   localparam int unsigned RSP_DATA_W   = 24;
   localparam int unsigned RSP_USER_W   = 3;

   // Reciprocal shift for the divide-by-alignment in the rounding unit
   localparam int unsigned RECIP_SHIFT  = 28;

   // Parameter defaults
   localparam int unsigned PAGE_BYTES_DEF  = 65536;
   localparam int unsigned ALIGN_BYTES_DEF = 256;
   localparam int unsigned MAX_PAGES_DEF   = 16;

   // Request kinds
   localparam logic CMD_ALLOC       = 1'b0;
   localparam logic CMD_FRAME_RESET = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_NO_PAGE  = 2'd2
   } status_type;

endpackage

@@ rtl/pba_ram.sv @@
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pba_ram #(
   parameter int unsigned WIDTH = 17,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pba_align.sv @@
// ----------------------------------------------------------------------------
// pba_align
// Three-stage unit that rounds a byte size up to a multiple of the alignment.
// ----------------------------------------------------------------------------
module pba_align #(
   parameter int unsigned ALIGN_BYTES = pba_pkg::ALIGN_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pba_pkg::SIZE_W-1:0]  size,
   output logic                        need_valid,
   output logic [pba_pkg::NEED_W-1:0]  need
);

   localparam int unsigned SW      = pba_pkg::SIZE_W;
   localparam int unsigned NW      = pba_pkg::NEED_W;
   localparam int unsigned SH      = pba_pkg::RECIP_SHIFT;
   localparam int unsigned RECIP_W = SH + 1;
   localparam int unsigned PROD_W  = SW + RECIP_W;
   localparam int unsigned A_W     = $clog2(ALIGN_BYTES + 1);
   localparam int unsigned RECIP   = (1 << SH) / ALIGN_BYTES;

   localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
   localparam logic [A_W-1:0]     ALIGN_C  = A_W'(ALIGN_BYTES);
   localparam logic [NW-1:0]      ALIGN_NW = NW'(ALIGN_BYTES);

   logic              v1_ff, v2_ff, v3_ff;
   logic [PROD_W-1:0] p1_ff, p1_in;
   logic [SW-1:0]     s1_ff, s2_ff;
   logic [NW-1:0]     p2_ff, p2_in;
   logic [SW-1:0]     q_est;
   logic [SW+A_W-1:0] mul2;
   logic [NW-1:0]     rem_raw, rem, need_ff, need_in;

   // Quotient estimate: at most one short of the true quotient
   assign p1_in = {{SW{1'b0}}, RECIP_C} * {{RECIP_W{1'b0}}, size};
   assign q_est = p1_ff[SH+SW-1:SH];
   assign mul2  = {{A_W{1'b0}}, q_est} * {{SW{1'b0}}, ALIGN_C};
   assign p2_in = NW'(mul2);

   always_comb begin
      rem_raw = NW'(s2_ff) - p2_ff;
      rem     = (rem_raw >= ALIGN_NW) ? (rem_raw - ALIGN_NW) : rem_raw;
      need_in = (rem == '0) ? NW'(s2_ff) : (NW'(s2_ff) + (ALIGN_NW - rem));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      // Advance each stage only with its item; hold the result until the next
      if (start) begin
         p1_ff <= p1_in;
         s1_ff <= size;
      end
      if (v1_ff) begin
         p2_ff <= p2_in;
         s2_ff <= s1_ff;
      end
      if (v2_ff) begin
         need_ff <= need_in;
      end
   end

   assign need_valid = v3_ff;
   assign need       = need_ff;

endmodule

@@ rtl/paged_bump_allocator_core.sv @@
// ----------------------------------------------------------------------------
// paged_bump_allocator_core
// Paged bump allocator with first-fit page choice and per-frame cursor reset.
// ----------------------------------------------------------------------------
// Usage: each req beat is either an allocate (req_tuser = 0, size in
// req_tdata) or a frame reset (req_tuser = 1). Every req beat yields exactly
// one rsp beat carrying page index, byte offset, discard flag and status.
// An allocate rounds the size up to ALIGN_BYTES in the rounding unit,
// then reads the open pages' cursors from the cursor RAM, one page per
// cycle, stopping at the first that fits; the RAM read port sets the
// scan rate. One item is in flight at a time; the next req beat can be
// taken in the cycle after the previous result enters the rsp register.
// A stalled receiver holds the rsp beat; the block then finishes the
// next item and waits with it.
// Reset clears all cursors (per-page valid bits, no RAM sweep) and the count
// of open pages; a frame reset clears the cursors but keeps the pages open.
// ----------------------------------------------------------------------------
module paged_bump_allocator_core #(
   parameter int unsigned PAGE_BYTES  = pba_pkg::PAGE_BYTES_DEF,
   parameter int unsigned ALIGN_BYTES = pba_pkg::ALIGN_BYTES_DEF,
   parameter int unsigned MAX_PAGES   = pba_pkg::MAX_PAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pba_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] request_size
   input  logic                              req_tuser,  // [0] cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pba_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [3:0] page_index,
                                                         // [19:4] byte_offset,
                                                         // [23:20] zero
   output logic [pba_pkg::RSP_USER_W-1:0]    rsp_tuser   // [0] discard_mode,
                                                         // [2:1] status
);

   localparam int unsigned NW     = pba_pkg::NEED_W;
   localparam int unsigned SW     = pba_pkg::SIZE_W;
   localparam int unsigned CUR_W  = $clog2(PAGE_BYTES + 1);
   localparam int unsigned SUM_W  = ((CUR_W > NW) ? CUR_W : NW) + 1;
   localparam int unsigned PIDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);

   localparam logic [SUM_W-1:0] PAGE_LIMIT = SUM_W'(PAGE_BYTES);
   localparam logic [CNT_W-1:0] PAGE_COUNT = CNT_W'(MAX_PAGES);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ALIGN = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SW-1:0]             size_ff, size_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      chk_valid_ff, chk_valid_in;
   logic [PIDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]          pages_open_ff, pages_open_in;
   logic [PIDX_W-1:0]         pick_ff, pick_in;
   logic [CUR_W-1:0]          off_ff, off_in;
   logic [MAX_PAGES-1:0]      cur_valid_ff, cur_valid_in;

   logic [pba_pkg::PAGE_IDX_W-1:0] res_page_ff, res_page_in;
   logic [pba_pkg::OFFSET_W-1:0]   res_off_ff, res_off_in;
   logic                           res_disc_ff, res_disc_in;
   pba_pkg::status_type            res_status_ff, res_status_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pba_pkg::PAGE_IDX_W-1:0] rsp_page_ff;
   logic [pba_pkg::OFFSET_W-1:0]   rsp_off_ff;
   logic                           rsp_disc_ff;
   pba_pkg::status_type            rsp_status_ff;

   logic              req_accept;
   logic              rsp_load;
   logic              align_start;
   logic              need_valid;
   logic [NW-1:0]     need;
   logic              ram_we;
   logic [PIDX_W-1:0] ram_waddr, ram_raddr;
   logic [CUR_W-1:0]  ram_wdata, ram_rdata;
   logic [CUR_W-1:0]  cur_value;
   logic [SUM_W-1:0]  need_ext;
   logic              page_fits;
   logic [SUM_W-1:0]  new_cursor;

   // Handshakes: take a request whenever no item is in flight
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid & req_tready;
   assign align_start = req_accept & (req_tuser == pba_pkg::CMD_ALLOC);
   assign rsp_load    = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_tready);

   pba_align #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_align (
      .clock      (clock),
      .reset      (reset),
      .start      (align_start),
      .size       (req_tdata),
      .need_valid (need_valid),
      .need       (need)
   );

   pba_ram #(
      .WIDTH (CUR_W),
      .DEPTH (MAX_PAGES)
   ) u_cursor_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // An entry never written since the last clear reads as zero
   assign cur_value  = cur_valid_ff[chk_idx_ff] ? ram_rdata : '0;
   assign need_ext   = SUM_W'(need);
   assign page_fits  = (SUM_W'(cur_value) + need_ext) <= PAGE_LIMIT;
   assign new_cursor = SUM_W'(off_ff) + need_ext;

   assign ram_raddr = rd_idx_ff[PIDX_W-1:0];
   assign ram_we    = (state_ff == ST_WRITE);
   assign ram_waddr = pick_ff;
   assign ram_wdata = CUR_W'(new_cursor);

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      rd_idx_in     = rd_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      pages_open_in = pages_open_ff;
      pick_in       = pick_ff;
      off_in        = off_ff;
      cur_valid_in  = cur_valid_ff;
      res_page_in   = res_page_ff;
      res_off_in    = res_off_ff;
      res_disc_in   = res_disc_ff;
      res_status_in = res_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               size_in = req_tdata;
               if (req_tuser == pba_pkg::CMD_FRAME_RESET) begin
                  // Drop every cursor; pages stay open
                  cur_valid_in  = '0;
                  res_page_in   = '0;
                  res_off_in    = '0;
                  res_disc_in   = 1'b0;
                  res_status_in = pba_pkg::STATUS_OK;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (need_valid) begin
               if (size_ff == '0 || need_ext > PAGE_LIMIT) begin
                  res_page_in   = '0;
                  res_off_in    = '0;
                  res_disc_in   = 1'b0;
                  res_status_in = pba_pkg::STATUS_BAD_SIZE;
                  state_in      = ST_DONE;
               end else begin
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue one cursor read a cycle; check the one read last cycle
            if (rd_idx_ff < pages_open_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[PIDX_W-1:0];
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end
            if (chk_valid_ff && page_fits) begin
               chk_valid_in = 1'b0;
               pick_in      = chk_idx_ff;
               off_in       = cur_value;
               state_in     = ST_WRITE;
            end else if (!chk_valid_ff && rd_idx_ff >= pages_open_ff) begin
               if (pages_open_ff >= PAGE_COUNT) begin
                  res_page_in   = '0;
                  res_off_in    = '0;
                  res_disc_in   = 1'b0;
                  res_status_in = pba_pkg::STATUS_NO_PAGE;
                  state_in      = ST_DONE;
               end else begin
                  // Open the next page with a zero cursor
                  pick_in       = pages_open_ff[PIDX_W-1:0];
                  off_in        = '0;
                  pages_open_in = pages_open_ff + CNT_W'(1);
                  state_in      = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cur_valid_in[pick_ff] = 1'b1;
            res_page_in   = pba_pkg::PAGE_IDX_W'(pick_ff);
            res_off_in    = pba_pkg::OFFSET_W'(off_ff);
            res_disc_in   = (off_ff == '0);
            res_status_in = pba_pkg::STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load from the result, clear once the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_valid_ff  <= 1'b0;
         pages_open_ff <= '0;
         cur_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         pages_open_ff <= pages_open_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      size_ff       <= size_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pick_ff       <= pick_in;
      off_ff        <= off_in;
      res_page_ff   <= res_page_in;
      res_off_ff    <= res_off_in;
      res_disc_ff   <= res_disc_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_page_ff   <= res_page_ff;
         rsp_off_ff    <= res_off_ff;
         rsp_disc_ff   <= res_disc_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_off_ff, rsp_page_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_disc_ff};

   // Checks
   a_pages_bounded: assert property (@(posedge clock) disable iff (reset)
      pages_open_ff <= PAGE_COUNT)
      else $error("open page count beyond page limit");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_valid_ff) |-> (CNT_W'(chk_idx_ff) < pages_open_ff))
      else $error("scan checked a page that is not open");

   a_cursor_fits: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (new_cursor <= PAGE_LIMIT))
      else $error("cursor update runs past the page end");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted request left no work in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the done state");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged bump allocator core. A scoreboard class
// keeps its own copy of the page cursors and the open-page count, predicts
// the grant for every accepted request beat and checks each response beat,
// field by field, in order. A directed opening walks the alignment edges,
// the bad-size case, page exhaustion and a frame reset. Random frames
// follow, each a frame reset and a run of allocations, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import pba_pkg::*;

   localparam int unsigned PAGE   = PAGE_BYTES_DEF;
   localparam int unsigned ALIGN  = ALIGN_BYTES_DEF;
   localparam int unsigned NPAGES = MAX_PAGES_DEF;
   localparam int unsigned RANDOM_ITEMS = 550;

   typedef struct packed {
      logic [PAGE_IDX_W-1:0] page;
      logic [OFFSET_W-1:0]   offset;
      logic                  discard;
      status_type            status;
   } grant_type;

   // Predicts one grant per accepted request and holds them until the
   // matching response beat arrives.
   class alloc_scoreboard;
      logic [NEED_W-1:0] cursor [NPAGES];
      logic [4:0]        pages_open;
      grant_type         grants_due [$];
      int                errors;

      function new();
         foreach (cursor[i]) cursor[i] = '0;
         pages_open = '0;
         errors     = 0;
      endfunction

      function int pending();
         return grants_due.size();
      endfunction

      function void note_request(logic cmd, logic [SIZE_W-1:0] size);
         grant_type   g;
         int unsigned need;
         int unsigned pick;
         bit          found;
         g      = '0;
         g.status = STATUS_OK;
         found  = 1'b0;
         pick   = 0;
         if (cmd == CMD_FRAME_RESET) begin
            foreach (cursor[i]) cursor[i] = '0;
         end else begin
            need = ((int'(size) + ALIGN - 1) / ALIGN) * ALIGN;
            if (size == '0 || need > PAGE) begin
               g.status = STATUS_BAD_SIZE;
            end else begin
               // first open page with room wins
               for (int i = 0; i < int'(pages_open); i++) begin
                  if (!found && int'(cursor[i]) + need <= PAGE) begin
                     pick  = i;
                     found = 1'b1;
                  end
               end
               if (!found && pages_open >= NPAGES) begin
                  g.status = STATUS_NO_PAGE;
               end else begin
                  if (!found) begin
                     pick = pages_open;
                     cursor[pick] = '0;
                     pages_open++;
                  end
                  g.page    = pick[PAGE_IDX_W-1:0];
                  g.offset  = cursor[pick][OFFSET_W-1:0];
                  g.discard = (cursor[pick] == '0);
                  cursor[pick] = cursor[pick] + need[NEED_W-1:0];
               end
            end
         end
         grants_due = {grants_due, g};
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_grant(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         grant_type want;
         if (grants_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat, expected none actual tdata %0h tuser %0h",
                     $time, data, user);
            return;
         end
         want = grants_due.pop_front();
         compare("page_index", want.page, data[3:0]);
         compare("byte_offset", want.offset, data[19:4]);
         compare("tdata pad", 0, data[23:20]);
         compare("discard_mode", want.discard, user[0]);
         compare("status", want.status, user[2:1]);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // [15:0] request_size
   logic                   req_tuser = 1'b0; // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // [3:0] page_index, [19:4] byte_offset
   logic [RSP_USER_W-1:0]  rsp_tuser;        // [0] discard_mode, [2:1] status

   alloc_scoreboard board = new();
   bit calm = 1'b0;   // when set, neither side idles
   int sent = 0;

   paged_bump_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard ceiling on the run; far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 19);
      if (roll < 13) return 0;
      if (roll < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Skew sizes toward small ones but keep the alignment edges, full-page
   // requests and the occasional zero in the mix.
   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(1, 255) * ALIGN;
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2:    return SIZE_W'($urandom_range(1, 65535));
         3:       return SIZE_W'(r);
         4:       return SIZE_W'($urandom_range(65280, 65535));
         5:       return SIZE_W'(r + $urandom_range(0, 2) - 1);
         default: return SIZE_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // Present one request beat and hold it until the block takes it. Valid
   // stays high into the next call, so a zero gap gives back-to-back beats.
   task automatic send(input logic cmd, input logic [SIZE_W-1:0] size);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= size;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, size);
      sent++;
   endtask

   // Drop valid and hold off until every outstanding grant has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // One frame: a frame reset, then a run of allocations. A greedy frame asks
   // for at least half a page each time, so pages fill and run out.
   task automatic run_frame(input bit greedy);
      int n;
      n = $urandom_range(4, 40);
      send(CMD_FRAME_RESET, SIZE_W'($urandom));
      for (int k = 0; k < n; k++) begin
         // stray frame reset in mid-run
         if ($urandom_range(0, 29) == 0) send(CMD_FRAME_RESET, SIZE_W'($urandom));
         send(CMD_ALLOC, greedy ? SIZE_W'($urandom_range(32768, 65535)) : pick_size());
      end
   endtask

   // Response side: check every accepted beat, then choose the next ready.
   initial begin : rsp_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_grant(rsp_tdata, rsp_tuser);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: alignment edges on page 0, then fill every page after page 0
      send(CMD_FRAME_RESET, 16'hFFFF);   // size ignored on a frame reset
      send(CMD_ALLOC, 16'd0);            // bad size
      send(CMD_ALLOC, 16'd1);            // opens page 0, offset zero, discard
      send(CMD_ALLOC, 16'd256);          // exact multiple
      send(CMD_ALLOC, 16'd255);          // one under
      send(CMD_ALLOC, 16'd257);          // one over, takes two slots
      for (int i = 1; i < NPAGES; i++) begin
         send(CMD_ALLOC, 16'hFFFF);      // rounds to a whole page, opens the next
      end
      send(CMD_ALLOC, 16'hFFFF);         // nothing fits, no page left
      send(CMD_ALLOC, 16'd1);            // still room on page 0
      send(CMD_FRAME_RESET, 16'h0000);   // cursors cleared, pages kept open
      send(CMD_ALLOC, 16'hFFFF);         // whole of page 0 again

      drain();

      // Random frames
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         run_frame($urandom_range(0, 7) == 0);
         if (!paused && sent > 300) begin
            drain();
            paused = 1'b1;
         end
      end
      calm = 1'b0;

      drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
